/* src/ascon_pkg.sv */
// Shared types, codes and constants for the ASCON-128 AEAD core (empty AD).
// No dependencies; imported by the controller, the datapath and the top level.
package ascon_pkg;

  // Field widths
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned RND_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned S_TDATA_W = 328;
  localparam int unsigned M_TDATA_W = 200;

  // Initialization vector for ASCON-128
  localparam logic [DATA_W-1:0] ASCON_IV = 64'h80400c0600000000;

  // Round indexes: twelve rounds run 0..11, six rounds run 6..11
  localparam logic [RND_W-1:0] RND_FIRST_FULL = 4'd0;
  localparam logic [RND_W-1:0] RND_FIRST_HALF = 4'd6;
  localparam logic [RND_W-1:0] RND_LAST       = 4'd11;

  // Input item kinds (tuser)
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ROUND  = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_DONE   = 4'b1000
  } ascon_state_e;

  // What follows the permutation rounds
  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_DATA,
    KIND_FINAL
  } ascon_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic             load_init;
    logic             absorb;
    logic             no_msg;
    logic             round_en;
    logic [RND_W-1:0] rnd_idx;
    logic             fin_init;
    logic             fin_tag;
    logic             load_out;
  } ascon_cmd_t;

  // Round constant for round index 0..11
  function automatic logic [7:0] round_const(logic [RND_W-1:0] idx);
    logic [7:0] rc;
    unique case (idx)
      4'd0:    rc = 8'hf0;
      4'd1:    rc = 8'he1;
      4'd2:    rc = 8'hd2;
      4'd3:    rc = 8'hc3;
      4'd4:    rc = 8'hb4;
      4'd5:    rc = 8'ha5;
      4'd6:    rc = 8'h96;
      4'd7:    rc = 8'h87;
      4'd8:    rc = 8'h78;
      4'd9:    rc = 8'h69;
      4'd10:   rc = 8'h5a;
      4'd11:   rc = 8'h4b;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

endpackage

/* src/ascon_ctrl.sv */
// Sequencing controller of the ASCON-128 core: accepts items, counts rounds,
// steers the datapath and owns the output valid flag. Depends on ascon_pkg.
module ascon_ctrl
  import ascon_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_cmd_i,
  input  logic       in_full_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ascon_cmd_t cmd_o
);

  ascon_state_e     state_q, state_d;
  ascon_kind_e      kind_q, kind_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic             open_q, open_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    rnd_d       = rnd_q;
    open_d      = open_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.rnd_idx = rnd_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == CMD_START) begin
            cmd_o.load_init = 1'b1;
            rnd_d   = RND_FIRST_FULL;
            kind_d  = KIND_INIT;
            open_d  = 1'b1;
            state_d = ST_ROUND;
          end else if (!open_q) begin
            cmd_o.no_msg = 1'b1;
            state_d = ST_DONE;
          end else if (in_full_i) begin
            cmd_o.absorb = 1'b1;
            rnd_d   = RND_FIRST_HALF;
            kind_d  = KIND_DATA;
            state_d = ST_ROUND;
          end else begin
            cmd_o.absorb = 1'b1;
            rnd_d   = RND_FIRST_FULL;
            kind_d  = KIND_FINAL;
            open_d  = 1'b0;
            state_d = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RND_LAST) begin
          state_d = (kind_q == KIND_DATA) ? ST_DONE : ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (kind_q == KIND_INIT) begin
          cmd_o.fin_init = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.fin_tag = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hand over to the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_DATA;
      rnd_q       <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      rnd_q       <= rnd_d;
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* src/ascon_dp.sv */
// Datapath of the ASCON-128 core: configuration registers, 320-bit state,
// one permutation round per cycle, absorb/pad logic and the output register.
// Depends on ascon_pkg.
module ascon_dp
  import ascon_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic [DATA_W-1:0]    nonce_hi_i,
  input  logic [DATA_W-1:0]    nonce_lo_i,
  input  logic [DATA_W-1:0]    data_word_i,
  input  logic [CNT_W-1:0]     byte_count_i,
  input  logic [DATA_W-1:0]    exp_tag_hi_i,
  input  logic [DATA_W-1:0]    exp_tag_lo_i,
  input  ascon_cmd_t           cmd_i,
  output logic [DATA_W-1:0]    data_out_o,
  output logic [CNT_W-1:0]     out_bytes_o,
  output logic                 final_block_o,
  output logic [DATA_W-1:0]    tag_hi_o,
  output logic [DATA_W-1:0]    tag_lo_o,
  output logic                 tag_match_o,
  output logic                 no_message_o
);

  typedef logic [4:0][DATA_W-1:0] state_t;

  function automatic logic [DATA_W-1:0] ror(logic [DATA_W-1:0] v, int unsigned n);
    return (v >> n) | (v << (DATA_W - n));
  endfunction

  // One ASCON permutation round
  function automatic state_t perm_round(state_t s, logic [7:0] rc);
    logic [DATA_W-1:0] a, b, c, d, e, t0, t1, t2, t3, t4;
    state_t r;
    a  = s[0] ^ s[4];
    b  = s[1];
    c  = s[2] ^ {56'd0, rc} ^ s[1];
    d  = s[3];
    e  = s[4] ^ s[3];
    t0 = a ^ (~b & c);
    t1 = b ^ (~c & d);
    t2 = c ^ (~d & e);
    t3 = d ^ (~e & a);
    t4 = e ^ (~a & b);
    t1 = t1 ^ t0;
    t0 = t0 ^ t4;
    t3 = t3 ^ t2;
    t2 = ~t2;
    r[0] = t0 ^ ror(t0, 19) ^ ror(t0, 28);
    r[1] = t1 ^ ror(t1, 61) ^ ror(t1, 39);
    r[2] = t2 ^ ror(t2, 1)  ^ ror(t2, 6);
    r[3] = t3 ^ ror(t3, 10) ^ ror(t3, 17);
    r[4] = t4 ^ ror(t4, 7)  ^ ror(t4, 41);
    return r;
  endfunction

  // Byte masks of a final block: kept message bytes and the padding byte
  function automatic logic [DATA_W-1:0] keep_mask(logic [2:0] cnt);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[DATA_W-1-8*i -: 8] = (4'(i) < {1'b0, cnt}) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] pad_mask(logic [2:0] cnt);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[DATA_W-1-8*i -: 8] = (3'(i) == cnt) ? 8'h80 : 8'h00;
    end
    return m;
  endfunction

  logic [DATA_W-1:0] key_hi_q, key_lo_q;
  logic              dec_q;
  state_t            x_q, x_d;

  // Result waiting for the output register
  logic [DATA_W-1:0] pend_data_q, pend_data_d;
  logic [CNT_W-1:0]  pend_bytes_q, pend_bytes_d;
  logic              pend_final_q, pend_final_d;
  logic              pend_nomsg_q, pend_nomsg_d;
  logic              pend_dec_q, pend_dec_d;
  logic              pend_match_q, pend_match_d;
  logic [DATA_W-1:0] exp_hi_q, exp_hi_d, exp_lo_q, exp_lo_d;

  logic [DATA_W-1:0] out_data_q, out_tag_hi_q, out_tag_lo_q;
  logic [CNT_W-1:0]  out_bytes_q;
  logic              out_final_q, out_match_q, out_nomsg_q;

  logic [DATA_W-1:0] keep, pad, msg, x0_abs, out_abs, tag_hi, tag_lo;
  logic [2:0]        cnt;
  logic              full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      dec_q    <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_KEY_HI) key_hi_q <= cfg_data_i;
      if (cfg_idx_i == CFG_KEY_LO) key_lo_q <= cfg_data_i;
      if (cfg_idx_i == CFG_DECRYPT) dec_q <= cfg_data_i[0];
    end
  end

  // Absorb one block: full blocks swap or add the word, short ones pad
  assign full = byte_count_i[CNT_W-1];
  assign cnt  = byte_count_i[2:0];
  assign keep = keep_mask(cnt);
  assign pad  = pad_mask(cnt);
  assign msg  = data_word_i & keep;

  always_comb begin
    if (full) begin
      x0_abs  = dec_q ? data_word_i : (x_q[0] ^ data_word_i);
      out_abs = x_q[0] ^ data_word_i;
    end else if (dec_q) begin
      x0_abs  = (msg | (x_q[0] & ~keep)) ^ pad;
      out_abs = (x_q[0] ^ msg) & keep;
    end else begin
      x0_abs  = x_q[0] ^ (msg | pad);
      out_abs = (x_q[0] ^ msg ^ pad) & keep;
    end
  end

  assign tag_hi = x_q[3] ^ key_hi_q;
  assign tag_lo = x_q[4] ^ key_lo_q;

  // State and pending result update
  always_comb begin
    x_d          = x_q;
    pend_data_d  = pend_data_q;
    pend_bytes_d = pend_bytes_q;
    pend_final_d = pend_final_q;
    pend_nomsg_d = pend_nomsg_q;
    pend_dec_d   = pend_dec_q;
    pend_match_d = pend_match_q;
    exp_hi_d     = exp_hi_q;
    exp_lo_d     = exp_lo_q;
    if (cmd_i.load_init) begin
      x_d[0] = ASCON_IV;
      x_d[1] = key_hi_q;
      x_d[2] = key_lo_q;
      x_d[3] = nonce_hi_i;
      x_d[4] = nonce_lo_i;
    end else if (cmd_i.absorb) begin
      x_d[0]       = x0_abs;
      pend_data_d  = out_abs;
      pend_bytes_d = full ? CNT_W'(8) : {1'b0, cnt};
      pend_final_d = !full;
      pend_nomsg_d = 1'b0;
      pend_dec_d   = dec_q;
      pend_match_d = 1'b0;
      exp_hi_d     = exp_tag_hi_i;
      exp_lo_d     = exp_tag_lo_i;
      if (!full) begin
        x_d[1] = x_q[1] ^ key_hi_q;
        x_d[2] = x_q[2] ^ key_lo_q;
      end
    end else if (cmd_i.no_msg) begin
      pend_data_d  = '0;
      pend_bytes_d = '0;
      pend_final_d = 1'b0;
      pend_nomsg_d = 1'b1;
      pend_match_d = 1'b0;
    end else if (cmd_i.round_en) begin
      x_d = perm_round(x_q, round_const(cmd_i.rnd_idx));
    end else if (cmd_i.fin_init) begin
      x_d[3] = tag_hi;
      x_d[4] = tag_lo ^ 64'd1;
    end else if (cmd_i.fin_tag) begin
      x_d[3]       = tag_hi;
      x_d[4]       = tag_lo;
      pend_match_d = pend_dec_q && (tag_hi == exp_hi_q) && (tag_lo == exp_lo_q);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    pend_data_q  <= pend_data_d;
    pend_bytes_q <= pend_bytes_d;
    pend_final_q <= pend_final_d;
    pend_nomsg_q <= pend_nomsg_d;
    pend_dec_q   <= pend_dec_d;
    pend_match_q <= pend_match_d;
    exp_hi_q     <= exp_hi_d;
    exp_lo_q     <= exp_lo_d;
  end

  // Output register; the tag sits in state words three and four
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q   <= pend_data_q;
      out_bytes_q  <= pend_bytes_q;
      out_final_q  <= pend_final_q;
      out_tag_hi_q <= pend_final_q ? x_q[3] : '0;
      out_tag_lo_q <= pend_final_q ? x_q[4] : '0;
      out_match_q  <= pend_final_q && pend_match_q;
      out_nomsg_q  <= pend_nomsg_q;
    end
  end

  assign data_out_o    = out_data_q;
  assign out_bytes_o   = out_bytes_q;
  assign final_block_o = out_final_q;
  assign tag_hi_o      = out_tag_hi_q;
  assign tag_lo_o      = out_tag_lo_q;
  assign tag_match_o   = out_match_q;
  assign no_message_o  = out_nomsg_q;

endmodule

/* src/ascon128_aead_no_ad_core.sv */
// ASCON-128 AEAD core, empty associated data. One permutation round per cycle.
// Start item: busy for accept, 12 rounds and key add; no result.
// Full data block: accept, 6 rounds, then load into the output register; the next
// item is taken after that load. Final block: accept, 12 rounds plus tag, then load;
// no open message: accept, then load. Output register frees the input side.
// Reset (rst_ni low, asynchronous) clears keys, mode, message-open and valids.
module ascon128_aead_no_ad_core
  import ascon_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // nonce_hi[63:0] nonce_lo[127:64] data_word[191:128] byte_count[195:192]
  // expected_tag_hi[259:196] expected_tag_lo[323:260], zero fill [327:324]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // cmd[0]
  input  logic                 s_axis_tuser,
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // data_out[63:0] out_bytes[67:64] tag_hi[131:68] tag_lo[195:132]
  // tag_match[196], zero fill [199:197]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // no_message[0]
  output logic                 m_axis_tuser,
  // final_block
  output logic                 m_axis_tlast
);

  ascon_cmd_t        cmd;
  logic [DATA_W-1:0] data_out, tag_hi, tag_lo;
  logic [CNT_W-1:0]  out_bytes;
  logic              tag_match;

  ascon_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_full_i   (s_axis_tdata[195]),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  ascon_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .nonce_hi_i    (s_axis_tdata[63:0]),
    .nonce_lo_i    (s_axis_tdata[127:64]),
    .data_word_i   (s_axis_tdata[191:128]),
    .byte_count_i  (s_axis_tdata[195:192]),
    .exp_tag_hi_i  (s_axis_tdata[259:196]),
    .exp_tag_lo_i  (s_axis_tdata[323:260]),
    .cmd_i         (cmd),
    .data_out_o    (data_out),
    .out_bytes_o   (out_bytes),
    .final_block_o (m_axis_tlast),
    .tag_hi_o      (tag_hi),
    .tag_lo_o      (tag_lo),
    .tag_match_o   (tag_match),
    .no_message_o  (m_axis_tuser)
  );

  // Pack the result fields
  assign m_axis_tdata = {3'b000, tag_match, tag_lo, tag_hi, out_bytes, data_out};

`ifndef ASSERT_OFF
  // A rejected data item never closes a message
  a_nomsg_not_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast && (m_axis_tdata[67:64] == 4'd0))
    else $error("no-message result carries message data");

  // Tags and tag match appear only on the closing result
  a_tag_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata[196:68] == '0))
    else $error("tag fields set on a non-final result");

  // An ordinary data result always carries a full block
  a_full_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast && !m_axis_tuser |-> (m_axis_tdata[67:64] == 4'd8))
    else $error("non-final data result with short byte count");
`endif

endmodule

/* verif/tb_ascon128_aead_no_ad_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the ASCON-128 AEAD core with empty associated data.
// Depends on ascon_pkg and ascon128_aead_no_ad_core; carries its own cipher model.
module tb_ascon128_aead_no_ad_core;
  import ascon_pkg::*;

  localparam int unsigned CLK_HALF    = 5;
  localparam int unsigned RST_CYCLES  = 12;
  localparam int unsigned WDOG_LIMIT  = 4000;
  localparam int unsigned DRAIN_WAIT  = 24;
  localparam int unsigned TAIL_WAIT   = 40;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASE_ITEMS = 185;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned NUM_ROWS    = 24;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum logic {EXP_PREDICT, EXP_NO_MSG} exp_kind_e;

  typedef struct packed {
    logic        cmd;
    logic [63:0] nonce_hi;
    logic [63:0] nonce_lo;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic [63:0] etag_hi;
    logic [63:0] etag_lo;
  } blk_item_t;

  typedef struct packed {
    logic [63:0] data_out;
    logic [3:0]  out_bytes;
    logic        final_block;
    logic [63:0] tag_hi;
    logic [63:0] tag_lo;
    logic        tag_match;
    logic        no_message;
  } block_res_t;

  typedef struct packed {
    row_kind_e            kind;
    exp_kind_e            ek;
    logic                 tag_ok;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]    cfg_val;
    blk_item_t            item;
  } row_t;

  localparam block_res_t NO_MSG_RES = '{data_out: 64'd0, out_bytes: 4'd0, final_block: 1'b0,
                                        tag_hi: 64'd0, tag_lo: 64'd0, tag_match: 1'b0,
                                        no_message: 1'b1};

  localparam logic [7:0] RC [12] = '{8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
                                     8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b};

  // DUT ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  // Cipher model state and its copy of the registers
  logic [63:0] ks_hi = '0;
  logic [63:0] ks_lo = '0;
  logic        dec_mode = 1'b0;
  logic [63:0] st [5] = '{default: '0};
  logic        msg_open = 1'b0;

  block_res_t  pending_res [$];
  int          err_cnt = 0;
  int          items_taken = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_token = 0;
  int          hold_seen = 0;
  int          hold_cnt = 0;
  int unsigned stall_cycles = 0;

  ascon128_aead_no_ad_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Run the last nrounds rounds of the permutation on the model state
  function automatic void permute_state(input int unsigned nrounds);
    logic [63:0] a, b, c, d, e;
    for (int unsigned r = 12 - nrounds; r < 12; r++) begin
      st[2] ^= {56'd0, RC[r]};
      st[0] ^= st[4]; st[4] ^= st[3]; st[2] ^= st[1];
      a = st[0]; b = st[1]; c = st[2]; d = st[3]; e = st[4];
      st[0] = a ^ (~b & c);
      st[1] = b ^ (~c & d);
      st[2] = c ^ (~d & e);
      st[3] = d ^ (~e & a);
      st[4] = e ^ (~a & b);
      st[1] ^= st[0]; st[0] ^= st[4]; st[3] ^= st[2]; st[2] = ~st[2];
      st[0] ^= rotr(st[0], 19) ^ rotr(st[0], 28);
      st[1] ^= rotr(st[1], 61) ^ rotr(st[1], 39);
      st[2] ^= rotr(st[2], 1) ^ rotr(st[2], 6);
      st[3] ^= rotr(st[3], 10) ^ rotr(st[3], 17);
      st[4] ^= rotr(st[4], 7) ^ rotr(st[4], 41);
    end
  endfunction

  // Advance the cipher model by one item; return 1 when a result is due
  function automatic bit cipher_step(input blk_item_t it, output block_res_t res);
    logic [63:0] keep, pad, msg, t3, t4;
    res = '0;
    if (it.cmd == CMD_START) begin
      st[0] = ASCON_IV; st[1] = ks_hi; st[2] = ks_lo;
      st[3] = it.nonce_hi; st[4] = it.nonce_lo;
      permute_state(12);
      st[3] ^= ks_hi;
      st[4] ^= ks_lo ^ 64'd1;
      msg_open = 1'b1;
      return 1'b0;
    end
    if (!msg_open) begin
      res.no_message = 1'b1;
      return 1'b1;
    end
    // full block, also for counts above eight
    if (it.byte_count >= 4'd8) begin
      if (dec_mode) begin
        res.data_out = st[0] ^ it.data_word;
        st[0] = it.data_word;
      end else begin
        st[0] ^= it.data_word;
        res.data_out = st[0];
      end
      res.out_bytes = 4'd8;
      permute_state(6);
      return 1'b1;
    end
    // padded final block, then finalization and tag
    keep = (it.byte_count == 4'd0) ? 64'd0 : (~64'd0 << (64 - 8 * it.byte_count));
    pad  = 64'h80 << (56 - 8 * it.byte_count);
    msg  = it.data_word & keep;
    if (dec_mode) begin
      res.data_out = (st[0] ^ msg) & keep;
      st[0] = (msg | (st[0] & ~keep)) ^ pad;
    end else begin
      st[0] ^= msg | pad;
      res.data_out = st[0] & keep;
    end
    res.out_bytes = it.byte_count;
    res.final_block = 1'b1;
    st[1] ^= ks_hi;
    st[2] ^= ks_lo;
    permute_state(12);
    t3 = st[3] ^ ks_hi;
    t4 = st[4] ^ ks_lo;
    st[3] = t3;
    st[4] = t4;
    res.tag_hi = t3;
    res.tag_lo = t4;
    res.tag_match = dec_mode && (t3 == it.etag_hi) && (t4 == it.etag_lo);
    msg_open = 1'b0;
    return 1'b1;
  endfunction

  // Tag that a final block would produce, model state left untouched
  function automatic logic [127:0] tag_peek(input blk_item_t it);
    logic [63:0] saved [5];
    logic        saved_open;
    block_res_t  res;
    saved = st;
    saved_open = msg_open;
    void'(cipher_step(it, res));
    st = saved;
    msg_open = saved_open;
    return {res.tag_hi, res.tag_lo};
  endfunction

  function automatic blk_item_t rand_item();
    blk_item_t it;
    it.cmd        = 1'($urandom_range(1));
    it.nonce_hi   = rand64();
    it.nonce_lo   = rand64();
    it.data_word  = rand64();
    it.byte_count = 4'($urandom_range(15));
    it.etag_hi    = rand64();
    it.etag_lo    = rand64();
    return it;
  endfunction

  function automatic row_t start_row(input logic [63:0] nhi, input logic [63:0] nlo);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.ek = EXP_PREDICT;
    r.item.cmd = CMD_START;
    r.item.nonce_hi = nhi;
    r.item.nonce_lo = nlo;
    return r;
  endfunction

  function automatic row_t data_row(input logic [63:0] dw, input logic [3:0] cnt,
                                    input logic [63:0] thi, input logic [63:0] tlo,
                                    input logic tag_ok, input exp_kind_e ek);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.ek = ek;
    r.tag_ok = tag_ok;
    r.item.cmd = CMD_DATA;
    r.item.data_word = dw;
    r.item.byte_count = cnt;
    r.item.etag_hi = thi;
    r.item.etag_lo = tlo;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic void set_idle(input idle_mode_e m);
    case (m)
      IDLE_SEND: begin send_idle_pct = 78; recv_idle_pct = 0; end
      IDLE_RECV: begin send_idle_pct = 0; recv_idle_pct = 78; end
      IDLE_BOTH: begin send_idle_pct = 19; recv_idle_pct = 19; end
      default:   begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endfunction

  // Write one register and mirror it in the model
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_KEY_HI:  ks_hi = val;
      CFG_KEY_LO:  ks_lo = val;
      CFG_DECRYPT: dec_mode = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Hold the input, wait for all results and for a start still in flight
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Offer one item, wait for its transfer, then record what it should produce
  task automatic send_item(input blk_item_t it, input exp_kind_e ek);
    block_res_t res;
    bit         has;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {4'd0, it.etag_lo, it.etag_hi, it.byte_count, it.data_word,
                      it.nonce_lo, it.nonce_hi};
    do @(posedge clk_i); while (!s_axis_tready);
    has = cipher_step(it, res);
    if (has) pending_res.push_back((ek == EXP_NO_MSG) ? NO_MSG_RES : res);
    if (!res.no_message) items_taken++;
  endtask

  // One message: start, full blocks, final block, with some noise mixed in
  task automatic run_message();
    blk_item_t it;
    int        nblk;
    it = rand_item();
    if ($urandom_range(99) < 5) begin
      it.cmd = CMD_DATA;
      send_item(it, EXP_PREDICT);
      return;
    end
    it.cmd = CMD_START;
    send_item(it, EXP_PREDICT);
    // restart on top of the open message
    if ($urandom_range(19) == 0) begin
      it = rand_item();
      it.cmd = CMD_START;
      send_item(it, EXP_PREDICT);
    end
    nblk = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(4);
    repeat (nblk) begin
      it = rand_item();
      it.cmd = CMD_DATA;
      it.byte_count = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'd8;
      send_item(it, EXP_PREDICT);
    end
    // change a register while the message is open
    if ($urandom_range(11) == 0) begin
      drain_pipe();
      case ($urandom_range(2))
        0:       write_reg(CFG_KEY_HI, rand64());
        1:       write_reg(CFG_KEY_LO, rand64());
        default: write_reg(CFG_DECRYPT, 64'(!dec_mode));
      endcase
    end
    // leave the message open now and then
    if ($urandom_range(9) == 0) return;
    it = rand_item();
    it.cmd = CMD_DATA;
    it.byte_count = 4'($urandom_range(7));
    if (dec_mode && ($urandom_range(1) == 1)) {it.etag_hi, it.etag_lo} = tag_peek(it);
    send_item(it, EXP_PREDICT);
  endtask

  // Check each result transfer and drive the receiver's ready
  always @(posedge clk_i) begin : rx_side
    block_res_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{data_out: m_axis_tdata[63:0], out_bytes: m_axis_tdata[67:64],
                final_block: m_axis_tlast, tag_hi: m_axis_tdata[131:68],
                tag_lo: m_axis_tdata[195:132], tag_match: m_axis_tdata[196],
                no_message: m_axis_tuser};
        if (pending_res.size() == 0) begin
          $error("result transfer with no expected result waiting");
          err_cnt++;
        end else begin
          want = pending_res.pop_front();
          if (got.data_out !== want.data_out) begin
            $error("data_out: expected %h, got %h", want.data_out, got.data_out);
            err_cnt++;
          end
          if (got.out_bytes !== want.out_bytes) begin
            $error("out_bytes: expected %0d, got %0d", want.out_bytes, got.out_bytes);
            err_cnt++;
          end
          if (got.final_block !== want.final_block) begin
            $error("final_block: expected %b, got %b", want.final_block, got.final_block);
            err_cnt++;
          end
          if (got.tag_hi !== want.tag_hi) begin
            $error("tag_hi: expected %h, got %h", want.tag_hi, got.tag_hi);
            err_cnt++;
          end
          if (got.tag_lo !== want.tag_lo) begin
            $error("tag_lo: expected %h, got %h", want.tag_lo, got.tag_lo);
            err_cnt++;
          end
          if (got.tag_match !== want.tag_match) begin
            $error("tag_match: expected %b, got %b", want.tag_match, got.tag_match);
            err_cnt++;
          end
          if (got.no_message !== want.no_message) begin
            $error("no_message: expected %b, got %b", want.no_message, got.no_message);
            err_cnt++;
          end
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_cnt != 0) begin
        m_axis_tready <= 1'b0;
        hold_cnt--;
      end else if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_cnt = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WDOG_LIMIT) begin
      $display("ascon128_aead_no_ad_core test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    row_t      dir_rows [NUM_ROWS];
    blk_item_t it;
    int        phase_start;
    int        ph;

    // Directed rows: extremes, every item kind, each special case
    dir_rows = '{
      data_row('1, 4'd8, '0, '0, 1'b0, EXP_NO_MSG),
      data_row(64'h0123456789abcdef, 4'd3, '0, '0, 1'b0, EXP_NO_MSG),
      start_row('0, '0),
      data_row('1, 4'd8, '0, '0, 1'b0, EXP_PREDICT),
      data_row('0, 4'd0, '0, '0, 1'b0, EXP_PREDICT),
      data_row(64'hfedcba9876543210, 4'd5, '1, '1, 1'b0, EXP_NO_MSG),
      start_row('1, '1),
      start_row(64'h0001020304050607, 64'h08090a0b0c0d0e0f),
      data_row('0, 4'd15, '0, '0, 1'b0, EXP_PREDICT),
      data_row('1, 4'd9, '0, '0, 1'b0, EXP_PREDICT),
      data_row('1, 4'd7, '0, '0, 1'b0, EXP_PREDICT),
      start_row(64'h8000000000000001, 64'h7ffffffffffffffe),
      data_row(64'ha5a5a5a5a5a5a5a5, 4'd1, '0, '0, 1'b0, EXP_PREDICT),
      cfg_row(CFG_KEY_HI, '1),
      cfg_row(CFG_KEY_LO, '1),
      cfg_row(CFG_DECRYPT, 64'd1),
      start_row('0, '1),
      data_row('1, 4'd8, '1, '1, 1'b0, EXP_PREDICT),
      data_row(64'h5a5a5a5a5a5a5a5a, 4'd4, '0, '0, 1'b1, EXP_PREDICT),
      start_row('1, '0),
      data_row('0, 4'd0, '0, '0, 1'b0, EXP_PREDICT),
      start_row(64'h0f1e2d3c4b5a6978, 64'h8796a5b4c3d2e1f0),
      data_row('1, 4'd7, '0, '0, 1'b1, EXP_PREDICT),
      data_row('0, 4'd8, '0, '0, 1'b0, EXP_NO_MSG)
    };

    // Reset once
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows without idling
    set_idle(IDLE_NONE);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_pipe();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        it = dir_rows[i].item;
        if (dir_rows[i].tag_ok) {it.etag_hi, it.etag_lo} = tag_peek(it);
        send_item(it, dir_rows[i].ek);
      end
    end

    // Random phases: each idling pattern in encrypt and in decrypt
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_pipe();
      set_idle(idle_mode_e'(ph % 4));
      write_reg(CFG_KEY_HI, (ph == 0) ? 64'd0 : (ph == 5) ? ~64'd0 : rand64());
      write_reg(CFG_KEY_LO, (ph == 0) ? 64'd0 : (ph == 5) ? ~64'd0 : rand64());
      write_reg(CFG_DECRYPT, 64'(ph >= NUM_PHASES / 2));
      if (ph % 4 == 0) hold_token++;
      phase_start = items_taken;
      while (items_taken - phase_start < PHASE_ITEMS) run_message();
    end

    // Wait out the remaining results and the tail latency
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (pending_res.size() != 0) begin
      $error("%0d expected results never arrived", pending_res.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("ascon128_aead_no_ad_core test passed");
    end else begin
      $display("ascon128_aead_no_ad_core test failed");
    end
    $finish;
  end

endmodule
